// ----- hw/rtl/ffha_pkg.sv -----
// Shared types, constants and command codes of the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
   localparam int HEAP_BYTES   = 4194304;
   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 16;
   localparam int ADDR_W = 22;
   localparam int SIZE_W = 23;
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int ALIGN_MASK    = 7;
   localparam int MIN_REMAINDER = 8;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OOM     = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
   localparam logic       FUNC_ALLOC     = 1'b0;
   localparam logic       FUNC_FREE      = 1'b1;

   typedef struct packed {
      logic              func;
      logic [SIZE_W-1:0] alloc_size;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic              free;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_ACCEPT, OP_READ, OP_SCAN, OP_FAIL, OP_SHIFT_START, OP_SHIFT_WR,
      OP_SPLIT_LO, OP_SPLIT_HI, OP_MARK, OP_MERGE_START, OP_MERGE_LOAD,
      OP_MERGE_STEP, OP_MERGE_END, OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic req_null;
      logic is_free;
      logic hit;
      logic last;
      logic can_split;
      logic shift_needed;
      logic shift_done;
      logic single;
      logic rsp_busy;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD, ST_EV, ST_FAIL, ST_ADEC, ST_SH_RD, ST_SH_WR, ST_SPLIT_LO,
      ST_SPLIT_HI, ST_M_INIT, ST_M_RD0, ST_M_LD, ST_M_RD, ST_M_EV, ST_M_END, ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ----- hw/rtl/ffha_datapath.sv -----
// Block table memory, scan and merge registers, and response register.
`timescale 1ns / 1ps
`default_nettype none
module ffha_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  ffha_pkg::dp_op_type   op,
   input  ffha_pkg::req_type     req_data,
   output ffha_pkg::dp_status_type status,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ffha_pkg::rsp_type     rsp_data
);
   import ffha_pkg::*;

   localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);
   localparam entry_type INIT_ENTRY = '{start: '0,
      size: ADDR_W'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};

   entry_type mem [MAX_BLOCKS];
   entry_type rdata_ff, acc_ff, acc_in, eff, wd;
   req_type   req_ff;
   rsp_type   res_ff, res_in, rsp_ff;
   logic [SIZE_W:0]  need_ff;
   logic [IDX_W-1:0] idx_ff, idx_in, hit_ff, hit_in, w_ff, w_in, wa;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, we;
   logic [SIZE_W:0]  need_calc;
   logic             merge_ok;

   assign need_calc = ({1'b0, req_data.alloc_size} + (SIZE_W+1)'(ALIGN_MASK))
                      & ~(SIZE_W+1)'(ALIGN_MASK);
   assign eff = '{start: rdata_ff.start, size: rdata_ff.size,
                  free: rdata_ff.free | (idx_ff == hit_ff)};
   assign merge_ok = acc_ff.free && eff.free;

   always_comb begin
      status.req_null = (req_data.func == FUNC_FREE) && (req_data.free_address == '0);
      status.is_free  = (req_ff.func == FUNC_FREE);
      if (req_ff.func == FUNC_FREE) begin
         status.hit = ({1'b0, rdata_ff.start} + (ADDR_W+1)'(HEADER_BYTES))
                      == {1'b0, req_ff.free_address};
      end else begin
         status.hit = rdata_ff.free && ({2'b0, rdata_ff.size} >= need_ff);
      end
      status.last  = ({1'b0, idx_ff} + CNT_W'(1)) == cnt_ff;
      status.can_split = ({2'b0, acc_ff.size} >=
                          need_ff + (SIZE_W+1)'(HEADER_BYTES + MIN_REMAINDER))
                         && (cnt_ff != CNT_W'(MAX_BLOCKS));
      status.shift_needed = ({1'b0, hit_ff} + CNT_W'(1)) < cnt_ff;
      status.shift_done   = idx_ff == (hit_ff + IDX_W'(1));
      status.single       = cnt_ff == CNT_W'(1);
      status.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      idx_in = idx_ff;
      hit_in = hit_ff;
      w_in   = w_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      we     = 1'b0;
      wa     = hit_ff;
      wd     = acc_ff;
      unique case (op)
         OP_ACCEPT: begin
            idx_in = '0;
            res_in = '{address: '0, status: STATUS_OK};
         end
         OP_SCAN: begin
            if (status.hit) begin
               hit_in = idx_ff;
               acc_in = rdata_ff;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         OP_FAIL: begin
            res_in.status = (req_ff.func == FUNC_FREE) ? STATUS_UNKNOWN : STATUS_OOM;
         end
         OP_SHIFT_START: idx_in = IDX_W'(cnt_ff - CNT_W'(1));
         OP_SHIFT_WR: begin
            we = 1'b1;
            wa = idx_ff + IDX_W'(1);
            wd = rdata_ff;
            idx_in = idx_ff - IDX_W'(1);
         end
         OP_SPLIT_LO: begin
            we = 1'b1;
            wd = '{start: acc_ff.start, size: need_ff[ADDR_W-1:0], free: 1'b0};
            res_in.address = acc_ff.start + HDR;
         end
         OP_SPLIT_HI: begin
            we = 1'b1;
            wa = hit_ff + IDX_W'(1);
            wd = '{start: acc_ff.start + HDR + need_ff[ADDR_W-1:0],
                   size: acc_ff.size - need_ff[ADDR_W-1:0] - HDR, free: 1'b1};
            cnt_in = cnt_ff + CNT_W'(1);
            res_in.address = acc_ff.start + HDR;
         end
         OP_MARK: begin
            we = 1'b1;
            wd = '{start: acc_ff.start, size: acc_ff.size, free: 1'b0};
            res_in.address = acc_ff.start + HDR;
         end
         OP_MERGE_START: begin
            idx_in = '0;
            w_in   = '0;
         end
         OP_MERGE_LOAD: begin
            acc_in = eff;
            idx_in = idx_ff + IDX_W'(1);
         end
         OP_MERGE_STEP: begin
            idx_in = idx_ff + IDX_W'(1);
            if (merge_ok) begin
               acc_in.size = acc_ff.size + HDR + eff.size;
            end else begin
               we     = 1'b1;
               wa     = w_ff;
               w_in   = w_ff + IDX_W'(1);
               acc_in = eff;
            end
         end
         OP_MERGE_END: begin
            we     = 1'b1;
            wa     = w_ff;
            cnt_in = {1'b0, w_ff} + CNT_W'(1);
         end
         OP_NOP, OP_READ, OP_PUBLISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem[0] <= INIT_ENTRY;
      end else if (we) begin
         mem[wa] <= wd;
      end
      if (op == OP_READ) begin
         rdata_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (op == OP_PUBLISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      w_ff   <= w_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      if (op == OP_ACCEPT) begin
         req_ff  <= req_data;
         need_ff <= need_calc;
      end
      if (op == OP_PUBLISH) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count out of range");
   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      we |-> ({1'b0, wa} <= cnt_ff))
      else $error("table write beyond the live entries");
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      op == OP_PUBLISH |-> !status.rsp_busy)
      else $error("response overwritten before transfer");
endmodule
`default_nettype wire

// ----- hw/rtl/ffha_ctrl.sv -----
// Sequencer for scan, split, shift and merge of the block table.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  ffha_pkg::dp_status_type status,
   output ffha_pkg::dp_op_type     op
);
   import ffha_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NOP;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_ACCEPT;
               state_in = status.req_null ? ST_DONE : ST_RD;
            end
         end
         ST_RD: begin
            op       = OP_READ;
            state_in = ST_EV;
         end
         ST_EV: begin
            op = OP_SCAN;
            if (status.hit) begin
               state_in = status.is_free ? ST_M_INIT : ST_ADEC;
            end else begin
               state_in = status.last ? ST_FAIL : ST_RD;
            end
         end
         ST_FAIL: begin
            op       = OP_FAIL;
            state_in = ST_DONE;
         end
         ST_ADEC: begin
            if (status.can_split) begin
               if (status.shift_needed) begin
                  op       = OP_SHIFT_START;
                  state_in = ST_SH_RD;
               end else begin
                  state_in = ST_SPLIT_LO;
               end
            end else begin
               op       = OP_MARK;
               state_in = ST_DONE;
            end
         end
         ST_SH_RD: begin
            op       = OP_READ;
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            op       = OP_SHIFT_WR;
            state_in = status.shift_done ? ST_SPLIT_LO : ST_SH_RD;
         end
         ST_SPLIT_LO: begin
            op       = OP_SPLIT_LO;
            state_in = ST_SPLIT_HI;
         end
         ST_SPLIT_HI: begin
            op       = OP_SPLIT_HI;
            state_in = ST_DONE;
         end
         ST_M_INIT: begin
            op       = OP_MERGE_START;
            state_in = ST_M_RD0;
         end
         ST_M_RD0: begin
            op       = OP_READ;
            state_in = ST_M_LD;
         end
         ST_M_LD: begin
            op       = OP_MERGE_LOAD;
            state_in = status.single ? ST_M_END : ST_M_RD;
         end
         ST_M_RD: begin
            op       = OP_READ;
            state_in = ST_M_EV;
         end
         ST_M_EV: begin
            op       = OP_MERGE_STEP;
            state_in = status.last ? ST_M_END : ST_M_RD;
         end
         ST_M_END: begin
            op       = OP_MERGE_END;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               op       = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request taken outside idle");
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted request not started");
   a_publish_idle: assert property (@(posedge clock) disable iff (reset)
      op == OP_PUBLISH |=> state_ff == ST_IDLE)
      else $error("publish did not return to idle");
endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_heap_allocator_core.sv -----
// Top level of the first-fit heap allocator: sequencer plus table datapath.
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator over a 64-entry address-ordered block table held in a
// single-port-write, registered-read memory. Each request is one transfer in and
// one transfer out. The scan reads and then evaluates each entry visited, a split
// reads and writes each entry shifted up, and a free runs a compacting merge pass
// over every live entry; a null free skips the table. No clearing pass is needed
// after reset. A finished response waits in an output register while the next
// request is taken.
module first_fit_heap_allocator_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  ffha_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output ffha_pkg::rsp_type   rsp_data
);
   import ffha_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   ffha_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire
